// ===== rtl/demand_paging_lru_frame_manager_defines.svh =====
// assertion macros for the lru frame manager
`ifndef DEMAND_PAGING_LRU_FRAME_MANAGER_DEFINES_SVH
`define DEMAND_PAGING_LRU_FRAME_MANAGER_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled while reset is low
`define DPL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("frame manager assertion failed");

// next-cycle implication, disabled while reset is low
`define DPL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("frame manager assertion failed");

`else

`define DPL_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define DPL_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/dplfm_pkg.sv =====
// shared types and request codes for the lru frame manager
`timescale 1ns / 1ps
package dplfm_pkg;

    localparam logic [1:0] REQ_ACCESS  = 2'd0;
    localparam logic [1:0] REQ_PRELOAD = 2'd1;
    localparam logic [1:0] REQ_RELEASE = 2'd2;
    localparam logic [1:0] REQ_NONE    = 2'd3;

    typedef struct packed {
        logic [1:0] req_type;
        logic [1:0] script_id;
        logic [5:0] line_index;
        logic [3:0] page_no;
    } t_req;

    typedef struct packed {
        logic       hit;
        logic       fault;
        logic       evicted;
        logic [3:0] frame_index;
        logic [1:0] line_offset;
        logic [1:0] victim_script;
        logic [3:0] victim_page;
        logic       status;
    } t_res;

endpackage

// ===== rtl/dplfm_ram.sv =====
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
module dplfm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/demand_paging_lru_frame_manager.sv =====
// demand paging frame manager with lru replacement, top level
//
//  channel   ports                     handshake
//  --------  ------------------------  -------------------------------------
//  request   i_req (t_req)             word taken when start && !busy
//  result    o_res (t_res)             one word per request, o_res_valid pulse
//
//  a fault into a free frame ends the scan at that frame; an eviction scans
//  all NUM_FRAMES frame times through the one comparator; a release clears
//  every page of its script. after reset the page map ram is swept clear
//  with busy high. the receiver cannot stall: o_res_valid marks each result
//  word on o_res for exactly one cycle.
`timescale 1ns / 1ps
`include "demand_paging_lru_frame_manager_defines.svh"
module demand_paging_lru_frame_manager #(
    parameter int NUM_FRAMES       = 16,
    parameter int LINES_PER_PAGE   = 4,
    parameter int NUM_SCRIPTS      = 4,
    parameter int PAGES_PER_SCRIPT = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  dplfm_pkg::t_req   i_req,
    output logic              o_res_valid,
    output dplfm_pkg::t_res   o_res
);

    import dplfm_pkg::*;

    localparam int FW        = $clog2(NUM_FRAMES);
    localparam int MAP_DEPTH = NUM_SCRIPTS * PAGES_PER_SCRIPT;
    localparam int MW        = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int SW        = (NUM_SCRIPTS > 1) ? $clog2(NUM_SCRIPTS) : 1;
    localparam int PGW       = (PAGES_PER_SCRIPT > 1) ? $clog2(PAGES_PER_SCRIPT) : 1;
    localparam int TW        = SW + PGW;
    // reciprocal for line / LINES_PER_PAGE, exact for 6-bit lines
    localparam int RECIP     = (4096 + LINES_PER_PAGE - 1) / LINES_PER_PAGE;

    localparam logic [MW-1:0] MAP_LAST = MW'(MAP_DEPTH - 1);
    localparam logic [MW-1:0] PG_LAST  = MW'(PAGES_PER_SCRIPT - 1);
    localparam logic [FW-1:0] FR_LAST  = FW'(NUM_FRAMES - 1);

    typedef enum logic [10:0] {
        S_INIT      = 11'b000_0000_0001,
        S_IDLE      = 11'b000_0000_0010,
        S_CLEAR     = 11'b000_0000_0100,
        S_LOOK      = 11'b000_0000_1000,
        S_MAPCHK    = 11'b000_0001_0000,
        S_SCAN      = 11'b000_0010_0000,
        S_SCAN_LAST = 11'b000_0100_0000,
        S_VREAD     = 11'b000_1000_0000,
        S_VMAP      = 11'b001_0000_0000,
        S_VCHK      = 11'b010_0000_0000,
        S_INSTALL   = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;

    logic [1:0]            r_req_type, n_req_type;
    logic [SW-1:0]         r_sid, n_sid;
    logic [PGW-1:0]        r_pg, n_pg;
    logic [3:0]            r_off, n_off;
    logic [MW-1:0]         r_slot, n_slot;
    logic [MW-1:0]         r_base, n_base;
    logic [MW-1:0]         r_cidx, n_cidx;
    logic [FW-1:0]         r_idx, n_idx;
    logic [FW-1:0]         r_prev, n_prev;
    logic                  r_cmp_pend, n_cmp_pend;
    logic                  r_first, n_first;
    logic [31:0]           r_best_time, n_best_time;
    logic [FW-1:0]         r_best_idx, n_best_idx;
    logic [FW-1:0]         r_vic, n_vic;
    logic                  r_evict, n_evict;
    logic [SW-1:0]         r_vs, n_vs;
    logic [PGW-1:0]        r_vp, n_vp;
    logic [MW-1:0]         r_vslot, n_vslot;
    logic [NUM_FRAMES-1:0] r_used, n_used;
    logic [31:0]           r_clock, n_clock;
    t_res                  r_res, n_res;
    logic                  r_res_valid, n_res_valid;

    // ram ports
    logic          map_we, map_re;
    logic [MW-1:0] map_waddr, map_raddr;
    logic [FW:0]   map_wdata, map_rd;
    logic          time_we, time_re;
    logic [FW-1:0] time_waddr, time_raddr;
    logic [31:0]   time_rd;
    logic          tag_we, tag_re;
    logic [FW-1:0] tag_raddr;
    logic [TW-1:0] tag_rd;

    // request decode
    logic [18:0]   w_div_prod;
    logic [5:0]    w_div_pg;
    logic [5:0]    w_pg;
    logic [5:0]    w_rem;
    logic [MW-1:0] w_slot, w_base, w_vslot;
    logic          w_bad;

    // shared lru comparator
    logic          w_take;
    logic [FW-1:0] w_cand_idx;

    always_comb begin
        w_div_prod = 19'(i_req.line_index) * 19'(RECIP);
        w_div_pg   = w_div_prod[17:12];
        w_rem      = i_req.line_index - 6'(int'(w_div_pg) * LINES_PER_PAGE);
        w_pg       = (i_req.req_type == REQ_ACCESS) ? w_div_pg : {2'b00, i_req.page_no};
        w_base     = MW'(int'(i_req.script_id) * PAGES_PER_SCRIPT);
        w_slot     = MW'(int'(i_req.script_id) * PAGES_PER_SCRIPT + int'(w_pg));
        w_bad      = (i_req.req_type == REQ_NONE)
                  || !(int'(i_req.script_id) < NUM_SCRIPTS)
                  || ((i_req.req_type != REQ_RELEASE) && !(int'(w_pg) < PAGES_PER_SCRIPT));
        w_vslot    = MW'(int'(tag_rd[TW-1:PGW]) * PAGES_PER_SCRIPT + int'(tag_rd[PGW-1:0]));
        w_take     = r_cmp_pend && (r_first || (time_rd < r_best_time));
        w_cand_idx = w_take ? r_prev : r_best_idx;
    end

    always_comb begin
        n_state     = r_state;
        n_req_type  = r_req_type;
        n_sid       = r_sid;
        n_pg        = r_pg;
        n_off       = r_off;
        n_slot      = r_slot;
        n_base      = r_base;
        n_cidx      = r_cidx;
        n_idx       = r_idx;
        n_prev      = r_prev;
        n_cmp_pend  = r_cmp_pend;
        n_first     = r_first;
        n_best_time = r_best_time;
        n_best_idx  = r_best_idx;
        n_vic       = r_vic;
        n_evict     = r_evict;
        n_vs        = r_vs;
        n_vp        = r_vp;
        n_vslot     = r_vslot;
        n_used      = r_used;
        n_clock     = r_clock;
        n_res       = r_res;
        n_res_valid = 1'b0;

        map_we     = 1'b0;
        map_waddr  = r_slot;
        map_wdata  = '0;
        map_re     = 1'b0;
        map_raddr  = r_slot;
        time_we    = 1'b0;
        time_waddr = r_vic;
        time_re    = 1'b0;
        time_raddr = r_idx;
        tag_we     = 1'b0;
        tag_re     = 1'b0;
        tag_raddr  = r_vic;

        unique case (r_state)
            S_INIT: begin
                // sweep the page map to unmapped
                map_we    = 1'b1;
                map_waddr = r_cidx;
                if (r_cidx == MAP_LAST) begin
                    n_cidx  = '0;
                    n_state = S_IDLE;
                end else begin
                    n_cidx = r_cidx + MW'(1);
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_req_type = i_req.req_type;
                    n_sid      = SW'(i_req.script_id);
                    n_pg       = PGW'(w_pg);
                    n_off      = w_rem[3:0];
                    n_slot     = w_slot;
                    n_base     = w_base;
                    n_cidx     = '0;
                    n_res      = '0;
                    if (w_bad) begin
                        n_res_valid = 1'b1;
                    end else if (i_req.req_type == REQ_RELEASE) begin
                        n_state = S_CLEAR;
                    end else begin
                        n_state = S_LOOK;
                    end
                end
            end
            S_CLEAR: begin
                map_we    = 1'b1;
                map_waddr = r_base + r_cidx;
                if (r_cidx == PG_LAST) begin
                    n_res_valid = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    n_cidx = r_cidx + MW'(1);
                end
            end
            S_LOOK: begin
                map_re  = 1'b1;
                n_state = S_MAPCHK;
            end
            S_MAPCHK: begin
                if (map_rd[FW]) begin
                    n_res.hit         = 1'b1;
                    n_res.frame_index = 4'(map_rd[FW-1:0]);
                    if (r_req_type == REQ_ACCESS) begin
                        // hit refreshes the frame time, preload hit does not
                        n_res.line_offset = 2'(r_off);
                        time_we           = 1'b1;
                        time_waddr        = map_rd[FW-1:0];
                        n_clock           = r_clock + 32'd1;
                    end
                    n_res_valid = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    n_idx      = '0;
                    n_cmp_pend = 1'b0;
                    n_first    = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                // frame time read at r_idx, compare of the one read last cycle
                time_re = 1'b1;
                if (w_take) begin
                    n_best_time = time_rd;
                    n_best_idx  = r_prev;
                    n_first     = 1'b0;
                end
                if (!r_used[r_idx]) begin
                    n_vic   = r_idx;
                    n_evict = 1'b0;
                    n_state = S_INSTALL;
                end else begin
                    n_prev     = r_idx;
                    n_cmp_pend = 1'b1;
                    if (r_idx == FR_LAST) begin
                        n_state = S_SCAN_LAST;
                    end else begin
                        n_idx = r_idx + FW'(1);
                    end
                end
            end
            S_SCAN_LAST: begin
                if (r_req_type == REQ_PRELOAD) begin
                    n_res.status = 1'b1;
                    n_res_valid  = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    n_vic   = w_cand_idx;
                    n_evict = 1'b1;
                    n_state = S_VREAD;
                end
            end
            S_VREAD: begin
                tag_re  = 1'b1;
                n_state = S_VMAP;
            end
            S_VMAP: begin
                n_vs      = tag_rd[TW-1:PGW];
                n_vp      = tag_rd[PGW-1:0];
                n_vslot   = w_vslot;
                map_re    = 1'b1;
                map_raddr = w_vslot;
                n_state   = S_VCHK;
            end
            S_VCHK: begin
                // unmap the victim only if its entry still names this frame
                if (map_rd[FW] && (map_rd[FW-1:0] == r_vic)) begin
                    map_we    = 1'b1;
                    map_waddr = r_vslot;
                end
                n_state = S_INSTALL;
            end
            S_INSTALL: begin
                time_we       = 1'b1;
                tag_we        = 1'b1;
                n_used[r_vic] = 1'b1;
                map_we        = 1'b1;
                map_waddr     = r_slot;
                map_wdata     = {1'b1, r_vic};
                n_clock       = r_clock + 32'd1;

                n_res.fault         = 1'b1;
                n_res.frame_index   = 4'(r_vic);
                n_res.evicted       = r_evict;
                n_res.victim_script = r_evict ? 2'(r_vs) : 2'd0;
                n_res.victim_page   = r_evict ? 4'(r_vp) : 4'd0;
                n_res.line_offset   = (r_req_type == REQ_ACCESS) ? 2'(r_off) : 2'd0;
                n_res_valid         = 1'b1;
                n_state             = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_cidx      <= '0;
            r_used      <= '0;
            r_clock     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cidx      <= n_cidx;
            r_used      <= n_used;
            r_clock     <= n_clock;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req_type  <= n_req_type;
        r_sid       <= n_sid;
        r_pg        <= n_pg;
        r_off       <= n_off;
        r_slot      <= n_slot;
        r_base      <= n_base;
        r_idx       <= n_idx;
        r_prev      <= n_prev;
        r_cmp_pend  <= n_cmp_pend;
        r_first     <= n_first;
        r_best_time <= n_best_time;
        r_best_idx  <= n_best_idx;
        r_vic       <= n_vic;
        r_evict     <= n_evict;
        r_vs        <= n_vs;
        r_vp        <= n_vp;
        r_vslot     <= n_vslot;
        r_res       <= n_res;
    end

    // page map: valid bit and frame number per script page
    dplfm_ram #(
        .WIDTH (FW + 1),
        .DEPTH (MAP_DEPTH)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_re    (map_re),
        .i_raddr (map_raddr),
        .o_rdata (map_rd)
    );

    // last-use time per frame
    dplfm_ram #(
        .WIDTH (32),
        .DEPTH (NUM_FRAMES)
    ) u_time_ram (
        .i_clk   (i_clk),
        .i_we    (time_we),
        .i_waddr (time_waddr),
        .i_wdata (r_clock),
        .i_re    (time_re),
        .i_raddr (time_raddr),
        .o_rdata (time_rd)
    );

    // owner script and page per frame
    dplfm_ram #(
        .WIDTH (TW),
        .DEPTH (NUM_FRAMES)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (tag_we),
        .i_waddr (r_vic),
        .i_wdata ({r_sid, r_pg}),
        .i_re    (tag_re),
        .i_raddr (tag_raddr),
        .o_rdata (tag_rd)
    );

    assign busy        = (r_state != S_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    `DPL_ASSERT_IMP(a_res_only_idle, i_clk, i_rst_n, o_res_valid, r_state == S_IDLE)
    `DPL_ASSERT_NXT(a_accept_reacts, i_clk, i_rst_n, start && !busy, busy || o_res_valid)
    `DPL_ASSERT_IMP(a_evict_is_fault, i_clk, i_rst_n, o_res_valid && o_res.evicted, o_res.fault && !o_res.hit)

endmodule

// ===== dv/demand_paging_lru_frame_manager_tb.sv =====
// self-checking testbench for the lru frame manager: directed table, then random requests
`timescale 1ns / 1ps
module demand_paging_lru_frame_manager_tb;
    import dplfm_pkg::*;

    localparam int NFRM = 16;
    localparam int NPAGE = 16;
    localparam t_res NO_RES = '0;

    typedef struct {
        t_req rq;
        bit   typed;
        t_res want;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    t_req i_req = '0;
    logic busy;
    logic o_res_valid;
    t_res o_res;

    // shadow of the frame table and page map
    logic        frm_used [NFRM];
    logic [1:0]  frm_owner [NFRM];
    logic [3:0]  frm_page [NFRM];
    logic [31:0] frm_stamp [NFRM];
    logic        map_ok [64];
    logic [3:0]  map_frm [64];
    logic [31:0] use_tick;

    t_res     res_due [$];
    t_dir_row dir_tab [$];
    int       err_cnt = 0;
    int       quiet_left = 0;

    demand_paging_lru_frame_manager dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

    always #10 i_clk = ~i_clk;

    initial begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic void clear_shadow();
        int i;
        for (i = 0; i < NFRM; i++) begin
            frm_used[i] = 1'b0;
            frm_owner[i] = '0;
            frm_page[i] = '0;
            frm_stamp[i] = '0;
        end
        for (i = 0; i < 64; i++) begin
            map_ok[i] = 1'b0;
            map_frm[i] = '0;
        end
        use_tick = '0;
    endfunction

    function automatic t_res predict_res(t_req r);
        t_res       o;
        int         f;
        int         i;
        logic [3:0] pg;
        logic [5:0] slot;
        logic [5:0] vslot;
        o = '0;
        if (r.req_type == REQ_NONE) return o;
        if (r.req_type == REQ_RELEASE) begin
            for (i = 0; i < NPAGE; i++) begin
                map_ok[{r.script_id, 4'(i)}] = 1'b0;
                map_frm[{r.script_id, 4'(i)}] = '0;
            end
            return o;
        end
        pg = (r.req_type == REQ_ACCESS) ? r.line_index[5:2] : r.page_no;
        slot = {r.script_id, pg};
        if (map_ok[slot]) begin
            f = map_frm[slot];
            o.hit = 1'b1;
            o.frame_index = 4'(f);
            // a preload hit leaves the time stamp alone
            if (r.req_type == REQ_ACCESS) begin
                o.line_offset = r.line_index[1:0];
                frm_stamp[f] = use_tick;
                use_tick = use_tick + 1;
            end
            return o;
        end
        f = -1;
        for (i = NFRM - 1; i >= 0; i--)
            if (!frm_used[i]) f = i;
        if (r.req_type == REQ_PRELOAD && f < 0) begin
            o.status = 1'b1;
            return o;
        end
        if (f < 0) begin
            f = 0;
            for (i = 1; i < NFRM; i++)
                if (frm_stamp[i] < frm_stamp[f]) f = i;
            vslot = {frm_owner[f], frm_page[f]};
            // only unmap when the owner's entry still names this frame
            if (map_ok[vslot] && map_frm[vslot] == 4'(f)) begin
                map_ok[vslot] = 1'b0;
                map_frm[vslot] = '0;
            end
            o.evicted = 1'b1;
            o.victim_script = frm_owner[f];
            o.victim_page = frm_page[f];
        end
        frm_used[f] = 1'b1;
        frm_owner[f] = r.script_id;
        frm_page[f] = pg;
        frm_stamp[f] = use_tick;
        use_tick = use_tick + 1;
        map_ok[slot] = 1'b1;
        map_frm[slot] = 4'(f);
        o.fault = 1'b1;
        o.frame_index = 4'(f);
        if (r.req_type == REQ_ACCESS) o.line_offset = r.line_index[1:0];
        return o;
    endfunction

    function automatic t_dir_row row(logic [1:0] t, logic [1:0] sid, logic [5:0] line,
                                     logic [3:0] pg, bit typed, t_res want);
        t_dir_row d;
        d.rq.req_type = t;
        d.rq.script_id = sid;
        d.rq.line_index = line;
        d.rq.page_no = pg;
        d.typed = typed;
        d.want = want;
        return d;
    endfunction

    task automatic issue_req(t_req r, bit typed, t_res want);
        int   gap;
        t_res p;
        if (quiet_left > 0) begin
            gap = 0;
            quiet_left--;
        end else begin
            gap = $urandom_range(0, 19);
            if ($urandom_range(0, 7) == 0) quiet_left = $urandom_range(10, 40);
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        forever begin
            @(posedge i_clk);
            if (busy === 1'b0) break;
        end
        p = predict_res(r);
        res_due.push_back(typed ? want : p);
    endtask

    always @(posedge i_clk) begin : res_mon
        t_res e;
        if (i_rst_n && o_res_valid === 1'b1) begin
            if (res_due.size() == 0) begin
                if (err_cnt < 10)
                    $display("result word with nothing pending: %h", o_res);
                err_cnt++;
            end else begin
                e = res_due.pop_front();
                if (o_res.hit !== e.hit || o_res.fault !== e.fault
                        || o_res.evicted !== e.evicted
                        || o_res.frame_index !== e.frame_index
                        || o_res.line_offset !== e.line_offset
                        || o_res.victim_script !== e.victim_script
                        || o_res.victim_page !== e.victim_page
                        || o_res.status !== e.status) begin
                    if (err_cnt < 10) begin
                        $display("mismatch exp h=%0b f=%0b e=%0b fr=%0d of=%0d vs=%0d vp=%0d s=%0b",
                                 e.hit, e.fault, e.evicted, e.frame_index, e.line_offset,
                                 e.victim_script, e.victim_page, e.status);
                        $display("         got h=%0b f=%0b e=%0b fr=%0d of=%0d vs=%0d vp=%0d s=%0b",
                                 o_res.hit, o_res.fault, o_res.evicted, o_res.frame_index,
                                 o_res.line_offset, o_res.victim_script, o_res.victim_page,
                                 o_res.status);
                    end
                    err_cnt++;
                end
            end
        end
    end

    initial begin : stim
        int   i;
        int   k;
        int   n_sent;
        t_req r;
        clear_shadow();

        dir_tab.push_back(row(REQ_NONE, 2'd3, 6'd63, 4'd15, 1, NO_RES));
        dir_tab.push_back(row(REQ_PRELOAD, 2'd0, 6'd0, 4'd0, 1,
                              '{1'b0, 1'b1, 1'b0, 4'd0, 2'd0, 2'd0, 4'd0, 1'b0}));
        dir_tab.push_back(row(REQ_ACCESS, 2'd0, 6'd63, 4'd0, 1,
                              '{1'b0, 1'b1, 1'b0, 4'd1, 2'd3, 2'd0, 4'd0, 1'b0}));
        dir_tab.push_back(row(REQ_ACCESS, 2'd0, 6'd1, 4'd0, 1,
                              '{1'b1, 1'b0, 1'b0, 4'd0, 2'd1, 2'd0, 4'd0, 1'b0}));
        // preload of a mapped page reports the hit without refreshing it
        dir_tab.push_back(row(REQ_PRELOAD, 2'd0, 6'd0, 4'd15, 1,
                              '{1'b1, 1'b0, 1'b0, 4'd1, 2'd0, 2'd0, 4'd0, 1'b0}));
        dir_tab.push_back(row(REQ_RELEASE, 2'd3, 6'd0, 4'd0, 1, NO_RES));
        // fill the remaining frames
        for (i = 0; i < 14; i++)
            dir_tab.push_back(row(REQ_PRELOAD, 2'd1, 6'd0, 4'(i), 0, NO_RES));
        dir_tab.push_back(row(REQ_PRELOAD, 2'd2, 6'd0, 4'd5, 1,
                              '{1'b0, 1'b0, 1'b0, 4'd0, 2'd0, 2'd0, 4'd0, 1'b1}));
        dir_tab.push_back(row(REQ_ACCESS, 2'd3, 6'd0, 4'd0, 0, NO_RES));
        // release, remap elsewhere, then evict the stale frame
        dir_tab.push_back(row(REQ_RELEASE, 2'd1, 6'd0, 4'd0, 0, NO_RES));
        dir_tab.push_back(row(REQ_ACCESS, 2'd1, 6'd0, 4'd0, 0, NO_RES));
        dir_tab.push_back(row(REQ_ACCESS, 2'd2, 6'd0, 4'd0, 0, NO_RES));
        dir_tab.push_back(row(REQ_ACCESS, 2'd1, 6'd1, 4'd0, 0, NO_RES));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[j])
            issue_req(dir_tab[j].rq, dir_tab[j].typed, dir_tab[j].want);

        n_sent = 0;
        while (n_sent < 1024) begin
            k = $urandom_range(0, 99);
            r.script_id = 2'($urandom_range(0, 3));
            r.line_index = 6'($urandom_range(0, 63));
            r.page_no = 4'($urandom_range(0, 15));
            if (k < 64) begin
                r.req_type = REQ_ACCESS;
                // hot working set so hits and refreshes stay common
                if ($urandom_range(0, 1) == 1) begin
                    r.script_id[1] = 1'b0;
                    r.line_index[5:4] = 2'b00;
                end
            end else if (k < 84) begin
                r.req_type = REQ_PRELOAD;
            end else if (k < 92) begin
                r.req_type = REQ_RELEASE;
            end else begin
                r.req_type = REQ_NONE;
            end
            n_sent++;
            issue_req(r, 0, NO_RES);
        end
        start <= 1'b0;

        while (res_due.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (err_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== demand_paging_lru_frame_manager.f =====
+incdir+rtl
rtl/dplfm_pkg.sv
rtl/dplfm_ram.sv
rtl/demand_paging_lru_frame_manager.sv
dv/demand_paging_lru_frame_manager_tb.sv
